// ===== rtl/cfp_pkg.sv =====
// Shared types and constants for the command frame parser.
package cfp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'hAB;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hBA;

	localparam logic REG_HEADER_FIRST  = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	localparam logic [7:0] CMD_PULSE    = 8'd8;
	localparam logic [7:0] CMD_CTRL_MAX = 8'd14;
	localparam logic [7:0] CMD_GAIN     = 8'd50;
	localparam logic [7:0] CMD_INTERVAL = 8'd98;
	localparam logic [7:0] CMD_MODE     = 8'd99;

	localparam logic [3:0] PULSE_TARGET = 4'd8;

	localparam logic [7:0] GAIN1_LSB_ADDR = 8'h0B;
	localparam logic [7:0] GAIN1_MSB_ADDR = 8'h0C;
	localparam logic [7:0] GAIN2_LSB_ADDR = 8'h0F;
	localparam logic [7:0] GAIN2_MSB_ADDR = 8'h10;

	localparam logic [31:0] MODE_MASK = 32'h0000_00FF;

	typedef enum logic [1:0] {
		KIND_CTRL     = 2'd0,
		KIND_GAIN     = 2'd1,
		KIND_INTERVAL = 2'd2,
		KIND_MODE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_CTRL     = 3'd0,
		OP_PULSE    = 3'd1,
		OP_GAIN     = 3'd2,
		OP_INTERVAL = 3'd3,
		OP_MODE     = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  target;
		logic [31:0] value;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/command_frame_parser_unit.sv =====
// Top level of the command frame parser: front, frame queue and action sequencer.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per item.
//   action channel (action_valid/action_ready/...) gives the decoded actions,
//   with last marking the final action of a frame.
//   cfg_we/cfg_index/cfg_data write the two header bytes (index 0, 1).
// Throughput: one byte per cycle in, one action per cycle out, while not stalled.
// Path: the frame is pushed into the queue when its last value byte is
//   accepted, and the sequencer then loads its first action into the output
//   register; a frame gives 0 to 4 actions, set by the sequencer's step counter.
// Reset: headers return to 0xAB 0xBA, the hunt restarts, the queue empties.
// Stall: the output register and a queue of QUEUE_DEPTH frames absorb a
//   stalled receiver; rx_ready drops only on the last byte of a frame
//   while the queue is full.
module command_frame_parser_unit #(
	parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        action_valid,
	input  logic        action_ready,
	output logic [1:0]  action_kind,
	output logic [3:0]  target_register,
	output logic [31:0] payload,
	output logic        last
);

	cfp_pkg::queue_stat_t q_stat;
	cfp_pkg::entry_t      q_entry;
	cfp_pkg::entry_t      q_head;
	logic                 q_push;
	logic                 q_pop;

	cfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	cfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	cfp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (q_head),
		.q_stat          (q_stat),
		.q_pop           (q_pop),
		.action_valid    (action_valid),
		.action_ready    (action_ready),
		.action_kind     (action_kind),
		.target_register (target_register),
		.payload         (payload),
		.last            (last)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("frame pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("frame popped from an empty queue");

	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(action_valid && (action_kind != cfp_pkg::KIND_CTRL)) |-> (target_register == 4'd0))
		else $error("nonzero target on a non-register action");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && (!action_valid || action_ready)) |=> !action_valid)
		else $error("action shown with no queued frame");
`endif

endmodule

// ===== rtl/cfp_front.sv =====
// Byte acceptance, header hunt, frame gathering and command classification.
module cfp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	input  cfp_pkg::queue_stat_t q_stat,
	output logic                 q_push,
	output cfp_pkg::entry_t      q_entry
);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'b001,
		PH_CMD   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [1:0]  byte_index_q;
	logic [7:0]  command_q;
	logic [23:0] gather_q;
	logic [7:0]  header_first_q;
	logic [7:0]  header_second_q;

	logic frame_end;
	logic accept;
	logic known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= cfp_pkg::HEADER_FIRST_RST;
			header_second_q <= cfp_pkg::HEADER_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfp_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				cfp_pkg::REG_HEADER_SECOND: header_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		frame_end = (phase_q == PH_VALUE) && (byte_index_q == 2'd3);
		rx_ready  = !(frame_end && q_stat.full);
		accept    = rx_valid && rx_ready;

		known          = 1'b1;
		q_entry.op     = cfp_pkg::OP_CTRL;
		q_entry.target = 4'd0;
		q_entry.value  = {gather_q, rx_byte};
		priority if (command_q == cfp_pkg::CMD_PULSE) begin
			q_entry.op     = cfp_pkg::OP_PULSE;
			q_entry.target = cfp_pkg::PULSE_TARGET;
		end else if (command_q <= cfp_pkg::CMD_CTRL_MAX) begin
			q_entry.op     = cfp_pkg::OP_CTRL;
			q_entry.target = command_q[3:0];
		end else if (command_q == cfp_pkg::CMD_GAIN) begin
			q_entry.op = cfp_pkg::OP_GAIN;
		end else if (command_q == cfp_pkg::CMD_INTERVAL) begin
			q_entry.op = cfp_pkg::OP_INTERVAL;
		end else if (command_q == cfp_pkg::CMD_MODE) begin
			q_entry.op = cfp_pkg::OP_MODE;
		end else begin
			known = 1'b0;
		end

		q_push = accept && frame_end && known;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			byte_index_q <= 2'd0;
			command_q    <= 8'd0;
			gather_q     <= 24'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_CMD: begin
					command_q    <= rx_byte;
					byte_index_q <= 2'd0;
					phase_q      <= PH_VALUE;
				end
				PH_VALUE: begin
					if (byte_index_q != 2'd3) begin
						gather_q     <= {gather_q[15:0], rx_byte};
						byte_index_q <= byte_index_q + 2'd1;
					end else begin
						byte_index_q <= 2'd0;
						phase_q      <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					if (byte_index_q == 2'd0) begin
						byte_index_q <= (rx_byte == header_first_q) ? 2'd1 : 2'd0;
					end else begin
						if (rx_byte == header_second_q) begin
							phase_q <= PH_CMD;
						end
						byte_index_q <= 2'd0;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/cfp_queue.sv =====
// Short queue of classified frames between the front and back parts.
module cfp_queue #(
	parameter int DEPTH = cfp_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cfp_pkg::entry_t       push_entry,
	input  logic                  pop,
	output cfp_pkg::entry_t       head,
	output cfp_pkg::queue_stat_t  stat
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	cfp_pkg::entry_t    mem_q [DEPTH];
	logic [ADDR_W-1:0]  wr_ptr_q;
	logic [ADDR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
		next_ptr = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/cfp_back.sv =====
// Action sequencer: expands each queued frame into its actions.
module cfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfp_pkg::entry_t      head,
	input  cfp_pkg::queue_stat_t q_stat,
	output logic                 q_pop,
	output logic                 action_valid,
	input  logic                 action_ready,
	output logic [1:0]           action_kind,
	output logic [3:0]           target_register,
	output logic [31:0]          payload,
	output logic                 last
);

	logic [1:0]  step_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  target_q;
	logic [31:0] payload_q;
	logic        last_q;

	logic           load;
	logic           take;
	cfp_pkg::kind_t nxt_kind;
	logic [3:0]     nxt_target;
	logic [31:0]    nxt_payload;
	logic           nxt_last;
	logic [7:0]     gain_addr;
	logic [7:0]     gain_byte;

	always_comb begin
		unique case (step_q)
			2'd0:    gain_addr = cfp_pkg::GAIN1_LSB_ADDR;
			2'd1:    gain_addr = cfp_pkg::GAIN1_MSB_ADDR;
			2'd2:    gain_addr = cfp_pkg::GAIN2_LSB_ADDR;
			default: gain_addr = cfp_pkg::GAIN2_MSB_ADDR;
		endcase
		gain_byte = step_q[0] ? head.value[15:8] : head.value[7:0];

		nxt_kind    = cfp_pkg::KIND_CTRL;
		nxt_target  = head.target;
		nxt_payload = head.value;
		nxt_last    = 1'b1;
		unique case (head.op)
			cfp_pkg::OP_PULSE: begin
				nxt_payload = {31'd0, (step_q == 2'd0)};
				nxt_last    = (step_q == 2'd1);
			end
			cfp_pkg::OP_GAIN: begin
				nxt_kind    = cfp_pkg::KIND_GAIN;
				nxt_payload = {16'd0, gain_addr, gain_byte};
				nxt_last    = (step_q == 2'd3);
			end
			cfp_pkg::OP_INTERVAL: begin
				nxt_kind = cfp_pkg::KIND_INTERVAL;
			end
			cfp_pkg::OP_MODE: begin
				nxt_kind    = cfp_pkg::KIND_MODE;
				nxt_payload = head.value & cfp_pkg::MODE_MASK;
			end
			default: ;
		endcase

		load  = !valid_q || action_ready;
		take  = load && !q_stat.empty;
		q_pop = take && nxt_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (take) begin
				step_q <= nxt_last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q    <= nxt_kind;
			target_q  <= nxt_target;
			payload_q <= nxt_payload;
			last_q    <= nxt_last;
		end
	end

	assign action_valid    = valid_q;
	assign action_kind     = kind_q;
	assign target_register = target_q;
	assign payload         = payload_q;
	assign last            = last_q;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the command frame parser: byte stream driver, action checker, frame predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLDOFF_LEN = 400;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'b001,
		PH_CMD   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef struct {
		cfp_pkg::kind_t kind;
		logic [3:0]     target;
		logic [31:0]    value;
		logic           last;
	} action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'h00;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        action_valid;
	logic        action_ready = 1'b0;
	logic [1:0]  action_kind;
	logic [3:0]  target_register;
	logic [31:0] payload;
	logic        last;

	logic [7:0]  byte_backlog[$];
	action_t     pending_actions[$];

	phase_t      prs_phase = PH_HUNT;
	logic [1:0]  prs_index = 2'd0;
	logic [7:0]  prs_cmd = 8'h00;
	logic [23:0] prs_gather = 24'h0;
	logic [7:0]  hdr_first = cfp_pkg::HEADER_FIRST_RST;
	logic [7:0]  hdr_second = cfp_pkg::HEADER_SECOND_RST;

	int bytes_pushed = 0;
	int bytes_taken = 0;
	int frames_sent = 0;
	int actions_seen = 0;
	int mismatches = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int cycles = 0;
	int holdoff_left = 0;
	logic holdoff_start = 1'b0;

	command_frame_parser_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.action_valid    (action_valid),
		.action_ready    (action_ready),
		.action_kind     (action_kind),
		.target_register (target_register),
		.payload         (payload),
		.last            (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic push_action(input cfp_pkg::kind_t k, input logic [3:0] t,
			input logic [31:0] v, input logic l);
		action_t a;
		a.kind = k;
		a.target = t;
		a.value = v;
		a.last = l;
		pending_actions.push_back(a);
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [31:0] v;
		logic [7:0] lo;
		logic [7:0] hi;
		case (prs_phase)
			PH_CMD: begin
				prs_cmd = b;
				prs_index = 2'd0;
				prs_phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (prs_index < 2'd3) begin
					prs_gather = {prs_gather[15:0], b};
					prs_index = prs_index + 2'd1;
				end else begin
					v = {prs_gather, b};
					lo = v[7:0];
					hi = v[15:8];
					prs_index = 2'd0;
					prs_phase = PH_HUNT;
					if (prs_cmd == cfp_pkg::CMD_PULSE) begin
						push_action(cfp_pkg::KIND_CTRL, cfp_pkg::PULSE_TARGET, 32'd1, 1'b0);
						push_action(cfp_pkg::KIND_CTRL, cfp_pkg::PULSE_TARGET, 32'd0, 1'b1);
					end else if (prs_cmd <= cfp_pkg::CMD_CTRL_MAX) begin
						push_action(cfp_pkg::KIND_CTRL, prs_cmd[3:0], v, 1'b1);
					end else if (prs_cmd == cfp_pkg::CMD_GAIN) begin
						push_action(cfp_pkg::KIND_GAIN, 4'd0,
							{16'h0000, cfp_pkg::GAIN1_LSB_ADDR, lo}, 1'b0);
						push_action(cfp_pkg::KIND_GAIN, 4'd0,
							{16'h0000, cfp_pkg::GAIN1_MSB_ADDR, hi}, 1'b0);
						push_action(cfp_pkg::KIND_GAIN, 4'd0,
							{16'h0000, cfp_pkg::GAIN2_LSB_ADDR, lo}, 1'b0);
						push_action(cfp_pkg::KIND_GAIN, 4'd0,
							{16'h0000, cfp_pkg::GAIN2_MSB_ADDR, hi}, 1'b1);
					end else if (prs_cmd == cfp_pkg::CMD_INTERVAL) begin
						push_action(cfp_pkg::KIND_INTERVAL, 4'd0, v, 1'b1);
					end else if (prs_cmd == cfp_pkg::CMD_MODE) begin
						push_action(cfp_pkg::KIND_MODE, 4'd0, v & cfp_pkg::MODE_MASK, 1'b1);
					end
				end
			end
			default: begin
				prs_phase = PH_HUNT;
				if (prs_index == 2'd0) begin
					prs_index = (b == hdr_first) ? 2'd1 : 2'd0;
				end else begin
					if (b == hdr_second)
						prs_phase = PH_CMD;
					prs_index = 2'd0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (rx_valid && rx_ready) begin
				parse_byte(rx_byte);
				bytes_taken++;
			end
			if (!rx_valid || rx_ready) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
					rx_valid <= 1'b1;
					rx_byte <= byte_backlog.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
		end else if (holdoff_start) begin
			holdoff_left <= HOLDOFF_LEN;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		action_t e;
		if (!arst_n) begin
			action_ready <= 1'b0;
		end else begin
			if (action_valid && action_ready) begin
				actions_seen++;
				if (pending_actions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected action: kind %0d target %0d payload %h last %0b",
							action_kind, target_register, payload, last);
				end else begin
					e = pending_actions.pop_front();
					if (action_kind !== e.kind || target_register !== e.target ||
							payload !== e.value || last !== e.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("action mismatch: expected kind %0d target %0d payload %h last %0b",
								e.kind, e.target, e.value, e.last);
							$display("                 got kind %0d target %0d payload %h last %0b",
								action_kind, target_register, payload, last);
						end
					end
				end
			end
			action_ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		byte_backlog.push_back(b);
		bytes_pushed++;
	endtask

	task automatic push_frame(input logic [7:0] cmd, input logic [31:0] v);
		push_byte(hdr_first);
		push_byte(hdr_second);
		push_byte(cmd);
		push_byte(v[31:24]);
		push_byte(v[23:16]);
		push_byte(v[15:8]);
		push_byte(v[7:0]);
		frames_sent++;
	endtask

	task automatic drain();
		while (bytes_taken != bytes_pushed || pending_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == cfp_pkg::REG_HEADER_FIRST)
			hdr_first = val;
		else
			hdr_second = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_headers(input logic [7:0] a, input logic [7:0] b);
		write_reg(cfp_pkg::REG_HEADER_FIRST, a);
		write_reg(cfp_pkg::REG_HEADER_SECOND, b);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(9))
			0, 1, 2: return 8'($urandom_range(cfp_pkg::CMD_CTRL_MAX));
			3: return cfp_pkg::CMD_PULSE;
			4, 5: return cfp_pkg::CMD_GAIN;
			6: return cfp_pkg::CMD_INTERVAL;
			7: return cfp_pkg::CMD_MODE;
			8: return 8'($urandom_range(255));
			default: return 8'($urandom_range(255, 15));
		endcase
	endfunction

	task automatic run_random(input int n_bytes);
		int start;
		int r;
		int k;
		start = bytes_pushed;
		while (bytes_pushed - start < n_bytes) begin
			r = $urandom_range(99);
			if (r < 78) begin
				push_frame(pick_cmd(), pick_value());
			end else if (r < 86) begin
				k = $urandom_range(4, 1);
				repeat (k) push_byte(8'($urandom_range(255)));
			end else if (r < 93) begin
				push_byte(hdr_first);
				push_byte($urandom_range(1) ? hdr_first : 8'($urandom_range(255)));
			end else begin
				push_byte(hdr_first);
				push_byte(hdr_second);
				push_byte(pick_cmd());
				k = $urandom_range(3);
				repeat (k) push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// header byte repeated: second copy is not rechecked as a first header byte
		push_byte(hdr_first);
		push_byte(hdr_first);
		push_byte(hdr_second);
		push_frame(cfp_pkg::CMD_CTRL_MAX, 32'hFFFF_FFFF);
		push_frame(cfp_pkg::CMD_PULSE, 32'h0000_0000);
		push_frame(cfp_pkg::CMD_GAIN, 32'h1234_A5FF);
		drain();

		set_headers(8'h00, 8'hFF);
		run_random(40);
		holdoff_start <= 1'b1;
		@(posedge clk);
		holdoff_start <= 1'b0;
		repeat (12) push_frame(cfp_pkg::CMD_GAIN, $urandom);
		run_random(40);
		drain();

		set_headers(8'hFF, 8'h00);
		send_idle = 81;
		run_random(90);
		drain();

		set_headers(8'($urandom_range(255)), 8'($urandom_range(255)));
		send_idle = 0;
		recv_stall = 81;
		run_random(45);
		drain();
		run_random(45);
		drain();

		set_headers(8'h5A, 8'h5A);
		send_idle = 23;
		recv_stall = 23;
		run_random(90);
		drain();

		mismatches += pending_actions.size();
		$display("Sent %0d bytes in %0d frames plus noise over five header settings,",
			bytes_pushed, frames_sent);
		$display("checked %0d actions under free flow, sender gaps, receiver stalls and holdoff.",
			actions_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
